// ===== hw/rtl/in_order_release_buffer_top_macros.svh =====
// Assertion macros for the in-order release buffer checker
`ifndef IN_ORDER_RELEASE_BUFFER_TOP_MACROS_SVH
`define IN_ORDER_RELEASE_BUFFER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define IORB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define IORB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iorb_pkg.sv =====
// Shared constants, item types and helpers for the in-order release buffer
package iorb_pkg;

    localparam int MAX_SLOTS    = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int ID_W         = 6;
    localparam int SLOT_AW      = $clog2(MAX_SLOTS);
    localparam int PTR_W        = $clog2(MAX_SLOTS + 2);
    localparam int CMP_W        = (PTR_W > ID_W) ? PTR_W : ID_W;
    localparam int QDEPTH       = 2;
    localparam int QAW          = $clog2(QDEPTH);
    localparam int QCW          = $clog2(QDEPTH + 1);

    localparam logic [ID_W-1:0] LEN_RESET = ID_W'(32);

    typedef struct packed {
        logic [ID_W-1:0]         slot_id;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] released_payload;
        logic [ID_W-1:0]         released_slot;
        logic                    last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [SLOT_AW-1:0]      idx;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    function automatic logic [CMP_W-1:0] active_len(input logic [ID_W-1:0] len);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(len);
        return (ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : ext;
    endfunction

endpackage

// ===== hw/rtl/in_order_release_buffer_top.sv =====
// The first result passes the front register, the job queue, the back end's check state,
// the slot RAM's registered read and the output register; then one release per cycle.
// busy stays high while the front register, the job queue or the back end holds work.
// The receiver cannot stall: each result is held for one cycle.
// Synchronous reset clears the filled bits, sets the release pointer to 1 and the
// length to 32; the payload RAM is not cleared.
module in_order_release_buffer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  iorb_pkg::t_in_item          i_item,
    input  logic                        i_cfg_we,
    input  logic [iorb_pkg::ID_W-1:0]   i_cfg_wdata,
    output logic                        o_result_strobe,
    output iorb_pkg::t_out_item         o_result
);
    import iorb_pkg::*;

    logic [ID_W-1:0]  r_stream_length;
    logic [CMP_W-1:0] len;
    logic             accept;
    logic             front_busy, back_busy;
    logic             q_full, q_empty, q_pop;
    t_push            push;
    t_job             head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_stream_length <= i_cfg_wdata;
        end
    end

    assign len    = active_len(r_stream_length);
    assign busy   = front_busy || !q_empty || back_busy;
    assign accept = start && !busy;

    iorb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_len    (len),
        .i_q_full (q_full),
        .o_push   (push),
        .o_busy   (front_busy)
    );

    iorb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    iorb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_len           (len),
        .i_empty         (q_empty),
        .i_head          (head),
        .o_pop           (q_pop),
        .o_busy          (back_busy),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

// ===== hw/rtl/iorb_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module iorb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/iorb_front.sv =====
// Front end: register accepted items, drop out-of-range ids, push jobs to the queue
module iorb_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  iorb_pkg::t_in_item         i_item,
    input  logic [iorb_pkg::CMP_W-1:0] i_len,
    input  logic                       i_q_full,
    output iorb_pkg::t_push            o_push,
    output logic                       o_busy
);
    import iorb_pkg::*;

    logic     r_valid, n_valid;
    t_in_item r_item;
    logic     in_range;

    always_comb begin
        in_range = (r_item.slot_id != '0) && (CMP_W'(r_item.slot_id) <= i_len);
        o_push.valid       = r_valid && in_range && !i_q_full;
        o_push.job.idx     = SLOT_AW'(r_item.slot_id - ID_W'(1));
        o_push.job.payload = r_item.payload;
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (r_valid && (!in_range || !i_q_full)) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    assign o_busy = r_valid;

endmodule

// ===== hw/rtl/iorb_queue.sv =====
// Short job queue between front and back ends
module iorb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iorb_pkg::t_push i_push,
    input  logic            i_pop,
    output iorb_pkg::t_job  o_head,
    output logic            o_full,
    output logic            o_empty
);
    import iorb_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == QCW'(QDEPTH));
        o_empty = (r_cnt == '0);
        do_push = i_push.valid && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wp    = do_push ? QAW'(r_wp + QAW'(1)) : r_wp;
        n_rp    = do_pop ? QAW'(r_rp + QAW'(1)) : r_rp;
        n_cnt   = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - QCW'(1);
        end
        o_head = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

endmodule

// ===== hw/rtl/iorb_back.sv =====
// Back end: store jobs, track filled slots, release runs in slot order
module iorb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [iorb_pkg::CMP_W-1:0] i_len,
    input  logic                       i_empty,
    input  iorb_pkg::t_job             i_head,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_result_strobe,
    output iorb_pkg::t_out_item        o_result
);
    import iorb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_back_state;

    t_back_state              r_state, n_state;
    logic [PTR_W-1:0]         r_ptr, n_ptr;
    logic [MAX_SLOTS-1:0]     r_filled, n_filled;
    logic                     r_strobe, n_strobe;
    t_out_item                r_out, n_out;
    logic [PTR_W-1:0]         ptr_inc;
    logic [SLOT_AW-1:0]       cur_idx, nxt_idx;
    logic                     cur_ok, nxt_ok;
    logic                     ram_re;
    logic [SLOT_AW-1:0]       ram_raddr;
    logic [PAYLOAD_BITS-1:0]  ram_rdata;

    iorb_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (i_head.idx),
        .i_wdata (i_head.payload),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ptr_inc  = r_ptr + PTR_W'(1);
        cur_idx  = SLOT_AW'(r_ptr - PTR_W'(1));
        nxt_idx  = r_ptr[SLOT_AW-1:0];
        cur_ok   = (CMP_W'(r_ptr) <= i_len) && r_filled[cur_idx];
        nxt_ok   = (CMP_W'(ptr_inc) <= i_len) && r_filled[nxt_idx];
        o_pop    = (r_state == S_IDLE) && !i_empty;
        o_busy   = (r_state != S_IDLE);

        n_state  = r_state;
        n_ptr    = r_ptr;
        n_filled = r_filled;
        n_strobe = 1'b0;
        n_out    = r_out;
        ram_re   = 1'b0;
        ram_raddr = cur_idx;

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_filled[i_head.idx] = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                ram_re    = cur_ok;
                ram_raddr = cur_idx;
                n_state   = cur_ok ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                ram_re    = nxt_ok;
                ram_raddr = nxt_idx;
                n_strobe  = 1'b1;
                n_out.released_payload = ram_rdata;
                n_out.released_slot    = ID_W'(r_ptr);
                n_out.last_of_run      = !nxt_ok;
                n_ptr     = ptr_inc;
                n_state   = nxt_ok ? S_EMIT : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= PTR_W'(1);
            r_filled <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_filled <= n_filled;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_out;

endmodule

// ===== hw/rtl/iorb_checker.sv =====
// Port-level checker for the in-order release buffer, bound to the top level
`include "in_order_release_buffer_top_macros.svh"

module iorb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_strobe,
    input iorb_pkg::t_out_item o_result
);

    `IORB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accept")
    `IORB_ASSERT_NOW(a_slot_nonzero, o_result_strobe, o_result.released_slot != '0, "slot zero released")
    `IORB_ASSERT_NEXT(a_run_continues, o_result_strobe && !o_result.last_of_run, o_result_strobe && (o_result.released_slot == $past(o_result.released_slot) + 6'd1), "run broken")
    `IORB_ASSERT_NEXT(a_run_ends, o_result_strobe && o_result.last_of_run, !o_result_strobe, "release after last of run")

endmodule

bind in_order_release_buffer_top iorb_checker u_iorb_checker (.*);
